### sv/swerve_wheel_kinematics_core_assert.svh
// ---------------------------------------------------------------------------
// Swerve wheel kinematics assertion macros
// Clocked property helpers shared by the core checks.
// ---------------------------------------------------------------------------
`ifndef SWERVE_WHEEL_KINEMATICS_CORE_ASSERT_SVH
`define SWERVE_WHEEL_KINEMATICS_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define SWK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SWK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/swk_pkg.sv
// ---------------------------------------------------------------------------
// Swerve wheel kinematics package
// Widths, fixed-point constants and the arctangent table of the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package swk_pkg;

    localparam int DATA_W       = 16;
    localparam int TXW          = 32;
    localparam int MS_W         = 15;
    localparam int SPD_W        = 16;
    localparam int STR_W        = 14;
    localparam int NUM_WHEELS   = 4;

    localparam logic [15:0] COS_Q15 = 16'd23180;
    localparam logic [15:0] SIN_Q15 = 16'd23161;
    localparam int Q15_SHIFT = 15;

    // Square root: one result bit per stage over a 64-bit radicand.
    localparam int SQ_W     = 64;
    localparam int SQ_STEPS = 32;

    // Speed scaling: floor(m * max_speed / 2^15 / 660).
    localparam int PROD_W               = 47;
    localparam logic [31:0] SPD_SAT     = 32'd43253760;
    localparam logic [26:0] SPD_RECIP   = 27'd104120420;
    localparam int QUOT_W               = 53;
    localparam int SPD_SHIFT            = 36;

    // CORDIC vectoring.
    localparam int CORDIC_STEPS = 19;
    localparam int CORDIC_PRE   = 32 - DATA_W;
    localparam int CW           = 52;
    localparam int ZW           = 23;
    localparam logic signed [ZW-1:0] HALF_TURN = 23'sd1048980;
    localparam logic signed [ZW-1:0] ANG_ROUND = 23'sd255;
    localparam int ANG_FRAC = 8;
    localparam logic signed [ZW-1:0] ANG_TAB [CORDIC_STEPS] = '{
        23'sd262245, 23'sd154812, 23'sd81799, 23'sd41522, 23'sd20842,
        23'sd10431,  23'sd5217,   23'sd2609,  23'sd1304,  23'sd652,
        23'sd326,    23'sd163,    23'sd82,    23'sd41,    23'sd20,
        23'sd10,     23'sd5,      23'sd3,     23'sd1
    };

    // Wheel datapath latency and the angle delay that aligns it with speed.
    localparam int WHEEL_LAT  = 37;
    localparam int ANG_DLY    = 16;
    localparam int FRONT_LAT  = 3;
    localparam int PIPE_DEPTH = FRONT_LAT + WHEEL_LAT;

endpackage

### sv/swerve_wheel_kinematics_core.sv
// ---------------------------------------------------------------------------
// Swerve wheel kinematics core
// Four-wheel swerve inverse kinematics: chassis command to wheel speed/angle.
// ---------------------------------------------------------------------------
// The core accepts one chassis command per clock and returns all four wheel
// speeds and steering angles; the latency is set by the
// 32-stage square root of the magnitude path, the CORDIC angle path is
// delayed to match. The whole pipeline advances together and holds when the
// result request is not taken. Write max_speed only while no command is in
// flight.
`timescale 1ns / 1ps

`include "swerve_wheel_kinematics_core_assert.svh"

module swerve_wheel_kinematics_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [swk_pkg::MS_W-1:0]            cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [swk_pkg::DATA_W-1:0]   s_lin_x,
    input  logic signed [swk_pkg::DATA_W-1:0]   s_lin_y,
    input  logic signed [swk_pkg::DATA_W-1:0]   s_yaw_rate,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [swk_pkg::SPD_W-1:0]           m_wheel0_speed,
    output logic [swk_pkg::SPD_W-1:0]           m_wheel1_speed,
    output logic [swk_pkg::SPD_W-1:0]           m_wheel2_speed,
    output logic [swk_pkg::SPD_W-1:0]           m_wheel3_speed,
    output logic signed [swk_pkg::STR_W-1:0]    m_wheel0_steer,
    output logic signed [swk_pkg::STR_W-1:0]    m_wheel1_steer,
    output logic signed [swk_pkg::STR_W-1:0]    m_wheel2_steer,
    output logic signed [swk_pkg::STR_W-1:0]    m_wheel3_steer
);

    localparam int TXW = swk_pkg::TXW;
    localparam int DW  = swk_pkg::DATA_W;

    logic                               en;
    logic [swk_pkg::MS_W-1:0]           max_speed_reg;
    logic [swk_pkg::PIPE_DEPTH-1:0]     vld_reg;

    assign en      = !vld_reg[swk_pkg::PIPE_DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[swk_pkg::PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= '0;
        end else if (cfg_wr_en) begin
            max_speed_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[swk_pkg::PIPE_DEPTH-2:0], s_valid};
        end
    end

    // Front end: capture, yaw products, wheel vectors.
    logic signed [DW-1:0]  in_x_reg, in_y_reg, in_w_reg;
    logic signed [DW-1:0]  bx_reg, by_reg;
    logic signed [TXW-1:0] wc_reg, ws_reg;
    logic signed [TXW-1:0] base_x, base_y;
    logic signed [TXW-1:0] tx_reg [swk_pkg::NUM_WHEELS];
    logic signed [TXW-1:0] ty_reg [swk_pkg::NUM_WHEELS];

    assign base_x = TXW'(bx_reg) <<< swk_pkg::Q15_SHIFT;
    assign base_y = TXW'(by_reg) <<< swk_pkg::Q15_SHIFT;

    always_ff @(posedge aclk) begin
        if (en) begin
            in_x_reg  <= s_lin_x;
            in_y_reg  <= s_lin_y;
            in_w_reg  <= s_yaw_rate;
            bx_reg    <= in_x_reg;
            by_reg    <= in_y_reg;
            wc_reg    <= TXW'(in_w_reg) * TXW'($signed(swk_pkg::COS_Q15));
            ws_reg    <= TXW'(in_w_reg) * TXW'($signed(swk_pkg::SIN_Q15));
            // Yaw signs per wheel: y + - - +, x + + - -.
            ty_reg[0] <= base_y + wc_reg;
            ty_reg[1] <= base_y - wc_reg;
            ty_reg[2] <= base_y - wc_reg;
            ty_reg[3] <= base_y + wc_reg;
            tx_reg[0] <= base_x + ws_reg;
            tx_reg[1] <= base_x + ws_reg;
            tx_reg[2] <= base_x - ws_reg;
            tx_reg[3] <= base_x - ws_reg;
        end
    end

    logic [swk_pkg::SPD_W-1:0]        speed [swk_pkg::NUM_WHEELS];
    logic signed [swk_pkg::STR_W-1:0] steer [swk_pkg::NUM_WHEELS];

    for (genvar k = 0; k < swk_pkg::NUM_WHEELS; k++) begin : g_wheel
        swk_wheel u_wheel (
            .aclk      (aclk),
            .en        (en),
            .max_speed (max_speed_reg),
            .tx        (tx_reg[k]),
            .ty        (ty_reg[k]),
            .speed     (speed[k]),
            .steer     (steer[k])
        );
    end

    assign m_wheel0_speed = speed[0];
    assign m_wheel1_speed = speed[1];
    assign m_wheel2_speed = speed[2];
    assign m_wheel3_speed = speed[3];
    assign m_wheel0_steer = steer[0];
    assign m_wheel1_steer = steer[1];
    assign m_wheel2_steer = steer[2];
    assign m_wheel3_steer = steer[3];

    `SWK_ASSERT_NEXT(a_accept_enters, s_valid && s_ready, vld_reg[0], "accepted request lost at entry")
    `SWK_ASSERT_NEXT(a_stall_holds, !s_ready, $stable(vld_reg), "pipeline moved during stall")
    `SWK_ASSERT_NEXT(a_drain_clears, m_valid && m_ready && !vld_reg[swk_pkg::PIPE_DEPTH-2], !m_valid, "result repeated")

endmodule

### sv/swk_wheel.sv
// ---------------------------------------------------------------------------
// Swerve wheel datapath
// Magnitude, speed scaling and CORDIC steering angle of one wheel vector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swk_wheel (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [swk_pkg::MS_W-1:0]        max_speed,
    input  logic signed [swk_pkg::TXW-1:0]  tx,
    input  logic signed [swk_pkg::TXW-1:0]  ty,
    output logic [swk_pkg::SPD_W-1:0]       speed,
    output logic signed [swk_pkg::STR_W-1:0] steer
);

    localparam int CW = swk_pkg::CW;
    localparam int ZW = swk_pkg::ZW;
    localparam int NS = swk_pkg::CORDIC_STEPS;
    localparam int NQ = swk_pkg::SQ_STEPS;

    // ---------------- magnitude ----------------
    logic [swk_pkg::TXW-1:0] ax, ay;
    logic [swk_pkg::SQ_W-1:0] sqx_reg, sqy_reg;
    logic [swk_pkg::SQ_W-1:0] sq_n_reg   [NQ+1];
    logic [swk_pkg::SQ_W-1:0] sq_res_reg [NQ+1];

    assign ax = tx[swk_pkg::TXW-1] ? swk_pkg::TXW'(-tx) : swk_pkg::TXW'(tx);
    assign ay = ty[swk_pkg::TXW-1] ? swk_pkg::TXW'(-ty) : swk_pkg::TXW'(ty);

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg       <= ax * ax;
            sqy_reg       <= ay * ay;
            sq_n_reg[0]   <= sqx_reg + sqy_reg;
            sq_res_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_sqrt
        localparam logic [swk_pkg::SQ_W-1:0] SQ_BIT = 64'd1 << (62 - 2 * k);
        logic [swk_pkg::SQ_W-1:0] trial;
        assign trial = sq_res_reg[k] + SQ_BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (sq_n_reg[k] >= trial) begin
                    sq_n_reg[k+1]   <= sq_n_reg[k] - trial;
                    sq_res_reg[k+1] <= (sq_res_reg[k] >> 1) + SQ_BIT;
                end else begin
                    sq_n_reg[k+1]   <= sq_n_reg[k];
                    sq_res_reg[k+1] <= sq_res_reg[k] >> 1;
                end
            end
        end
    end

    // ---------------- speed scaling ----------------
    logic [swk_pkg::PROD_W-1:0] prod_reg;
    logic [31:0]                scaled;
    logic                       sat_reg;
    logic [swk_pkg::QUOT_W-1:0] quot_reg;
    logic [swk_pkg::SPD_W-1:0]  speed_reg;

    assign scaled = prod_reg[swk_pkg::PROD_W-1:swk_pkg::Q15_SHIFT];

    // Below the saturation point the scaled value is under 2^26, where the
    // reciprocal product gives the exact quotient by 660.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= sq_res_reg[NQ][31:0] * max_speed;
            sat_reg   <= (scaled >= swk_pkg::SPD_SAT);
            quot_reg  <= scaled[25:0] * swk_pkg::SPD_RECIP;
            speed_reg <= sat_reg ? '1
                                 : quot_reg[swk_pkg::SPD_SHIFT+swk_pkg::SPD_W-1:swk_pkg::SPD_SHIFT];
        end
    end

    // ---------------- steering angle ----------------
    logic signed [CW-1:0] xs, ys;
    logic signed [CW-1:0] cx_reg [NS+1];
    logic signed [CW-1:0] cy_reg [NS+1];
    logic signed [ZW-1:0] cz_reg [NS+1];
    logic                 czero_reg [NS+1];

    assign xs = CW'(ty) <<< swk_pkg::CORDIC_PRE;
    assign ys = CW'(tx) <<< swk_pkg::CORDIC_PRE;

    // A vector pointing backward is turned by a half turn first.
    always_ff @(posedge aclk) begin
        if (en) begin
            czero_reg[0] <= (tx == '0) && (ty == '0);
            if (ty[swk_pkg::TXW-1]) begin
                cx_reg[0] <= -xs;
                cy_reg[0] <= -ys;
                cz_reg[0] <= tx[swk_pkg::TXW-1] ? -swk_pkg::HALF_TURN : swk_pkg::HALF_TURN;
            end else begin
                cx_reg[0] <= xs;
                cy_reg[0] <= ys;
                cz_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        logic signed [CW-1:0] xsh, ysh;
        assign xsh = cx_reg[i] >>> i;
        assign ysh = cy_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                czero_reg[i+1] <= czero_reg[i];
                if (!cy_reg[i][CW-1]) begin
                    cx_reg[i+1] <= cx_reg[i] + ysh;
                    cy_reg[i+1] <= cy_reg[i] - xsh;
                    cz_reg[i+1] <= cz_reg[i] + swk_pkg::ANG_TAB[i];
                end else begin
                    cx_reg[i+1] <= cx_reg[i] - ysh;
                    cy_reg[i+1] <= cy_reg[i] + xsh;
                    cz_reg[i+1] <= cz_reg[i] - swk_pkg::ANG_TAB[i];
                end
            end
        end
    end

    logic signed [ZW-1:0]            z_adj, z_q;
    logic signed [swk_pkg::STR_W-1:0] ang_reg;
    logic signed [swk_pkg::STR_W-1:0] ang_dly_reg [swk_pkg::ANG_DLY];

    // Truncate toward zero when dropping the fraction bits.
    assign z_adj = cz_reg[NS][ZW-1] ? cz_reg[NS] + swk_pkg::ANG_ROUND : cz_reg[NS];
    assign z_q   = z_adj >>> swk_pkg::ANG_FRAC;

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg        <= czero_reg[NS] ? '0 : z_q[swk_pkg::STR_W-1:0];
            ang_dly_reg[0] <= ang_reg;
            for (int d = 1; d < swk_pkg::ANG_DLY; d++) begin
                ang_dly_reg[d] <= ang_dly_reg[d-1];
            end
        end
    end

    assign speed = speed_reg;
    assign steer = ang_dly_reg[swk_pkg::ANG_DLY-1];

endmodule
